>>> rtl/core/linear_probe_hash_table_unit_assert.svh
// Assertion macros shared by the hash table checker.
// Needs a clock and an active-low reset named clk and rst_n in scope.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication checked at every edge out of reset
`define LPHT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht check failed");

// Next-cycle implication checked at every edge out of reset
`define LPHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht check failed");

`endif

>>> rtl/core/lpht_pkg.sv
// Types, codes and defaults for the linear probing hash table.
// No dependencies; every file of the block but the interfaces and the assertion header imports it.
`timescale 1ns / 1ps
`default_nettype none
package lpht_pkg;

  localparam int DEF_SLOTS      = 256;
  localparam int DEF_KEY_BITS   = 64;
  localparam int DEF_VALUE_BITS = 64;
  localparam logic [8:0] LIMIT_RESET = 9'd170;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_MISS  = 2'd1,
    STS_FULL  = 2'd2,
    STS_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HMOD,
    S_PRD,
    S_PCHK,
    S_TRD,
    S_TCHK,
    S_ERD,
    S_ECHK,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/lpht_if.sv
// Channel interfaces of the hash table: request, result and configuration.
// Depends on nothing; each carries valid, ready and its payload.
`timescale 1ns / 1ps
`default_nettype none
interface lpht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] search_key;
  logic [7:0]  home_slot;
  logic [7:0]  target_slot;
  logic [63:0] write_value;
  modport source (output valid, opcode, search_key, home_slot, target_slot, write_value,
                  input ready);
  modport sink (input valid, opcode, search_key, home_slot, target_slot, write_value,
                output ready);
endinterface

interface lpht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  result_slot;
  logic [63:0] result_value;
  logic        newly_inserted;
  logic [8:0]  occupied_count;
  modport source (output valid, status, result_slot, result_value, newly_inserted,
                  occupied_count, input ready);
  modport sink (input valid, status, result_slot, result_value, newly_inserted,
                occupied_count, output ready);
endinterface

interface lpht_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] load_limit;
  modport source (output valid, load_limit, input ready);
  modport sink (input valid, load_limit, output ready);
endinterface
`default_nettype wire

>>> rtl/core/linear_probe_hash_table_unit.sv
// Linear probing hash table: one request in, one result out per beat.
// Sequence: lookup/insert reduce the home slot, then read and check one probed slot at a time;
// erase and write value read the target slot; erase then backward-shifts the following run.
// One item at a time; the slot memory with one write port and a registered read sets the pace.
// Reset: synchronous, active low; then a clearing pass over every slot empties the
// table before the first request is taken. Configuration writes are taken always.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table_unit
  import lpht_pkg::*;
#(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire         clk,
  input  wire         rst_n,
  lpht_req_if.sink    in_ch,
  lpht_rsp_if.source  out_ch,
  lpht_cfg_if.sink    cfg_ch
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int HW = (SW > 8) ? SW : 8;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  // Slot memory
  logic              mem_valid [SLOTS];
  logic [SW-1:0]     mem_home  [SLOTS];
  logic [KEY_BITS-1:0]   mem_key [SLOTS];
  logic [VALUE_BITS-1:0] mem_val [SLOTS];

  logic                  rd_valid_r;
  logic [SW-1:0]         rd_home_r;
  logic [KEY_BITS-1:0]   rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;

  logic                  we;
  logic [SW-1:0]         wa;
  logic                  w_valid;
  logic [SW-1:0]         w_home;
  logic [KEY_BITS-1:0]   w_key;
  logic [VALUE_BITS-1:0] w_val;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [HW-1:0]         home_r, home_nxt;
  logic [VALUE_BITS-1:0] wval_r, wval_nxt;
  logic [SW-1:0]         pos_r, pos_nxt;
  logic [SW-1:0]         hole_r, hole_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [8:0]            limit_r;

  status_t               res_status_r, res_status_nxt;
  logic [7:0]            res_slot_r, res_slot_nxt;
  logic [63:0]           res_val_r, res_val_nxt;
  logic                  res_fresh_r, res_fresh_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  logic [7:0]            out_slot_r;
  logic [63:0]           out_val_r;
  logic                  out_fresh_r;
  logic [8:0]            out_count_r;
  logic                  out_load;

  logic [SW-1:0]         pos_next;
  logic [SW:0]           dist_wide;
  logic [SW-1:0]         home_dist;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_valid[wa] <= w_valid;
      mem_home[wa]  <= w_home;
      mem_key[wa]   <= w_key;
      mem_val[wa]   <= w_val;
    end
    rd_valid_r <= mem_valid[pos_r];
    rd_home_r  <= mem_home[pos_r];
    rd_key_r   <= mem_key[pos_r];
    rd_val_r   <= mem_val[pos_r];
  end

  // Next slot with wrap, and distance of the read entry from its home
  assign pos_next  = (pos_r == LAST_SLOT) ? '0 : pos_r + 1'b1;
  assign dist_wide = (rd_home_r <= pos_r) ? ({1'b0, pos_r} - {1'b0, rd_home_r})
                   : ({1'b0, pos_r} + (SW + 1)'(SLOTS) - {1'b0, rd_home_r});
  assign home_dist = dist_wide[SW-1:0];

  // Configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      limit_r <= cfg_ch.load_limit;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pos_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    home_r       <= home_nxt;
    wval_r       <= wval_nxt;
    hole_r       <= hole_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_val_r    <= res_val_nxt;
    res_fresh_r  <= res_fresh_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_val_r    <= res_val_r;
      out_fresh_r  <= res_fresh_r;
      out_count_r  <= 9'(count_r);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    home_nxt       = home_r;
    wval_nxt       = wval_r;
    pos_nxt        = pos_r;
    hole_nxt       = hole_r;
    cnt_nxt        = cnt_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_val_nxt    = res_val_r;
    res_fresh_nxt  = res_fresh_r;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    we             = 1'b0;
    wa             = pos_r;
    w_valid        = 1'b0;
    w_home         = rd_home_r;
    w_key          = rd_key_r;
    w_val          = rd_val_r;

    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        if (pos_r == LAST_SLOT) begin
          pos_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt = pos_next;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt         = op_t'(in_ch.opcode);
          key_nxt        = KEY_BITS'(in_ch.search_key);
          home_nxt       = HW'(in_ch.home_slot);
          wval_nxt       = VALUE_BITS'(in_ch.write_value);
          res_status_nxt = STS_OK;
          res_slot_nxt   = in_ch.target_slot;
          res_val_nxt    = '0;
          res_fresh_nxt  = 1'b0;
          cnt_nxt        = '0;
          if (op_t'(in_ch.opcode) == OP_LOOKUP || op_t'(in_ch.opcode) == OP_INSERT) begin
            state_nxt = S_HMOD;
          end else if (32'(in_ch.target_slot) >= SLOTS) begin
            res_status_nxt = STS_EMPTY;
            state_nxt      = S_FIN;
          end else begin
            pos_nxt   = SW'(in_ch.target_slot);
            state_nxt = S_TRD;
          end
        end
      end
      S_HMOD: begin
        // reduce the home slot modulo the table size, one subtract per cycle
        if (32'(home_r) >= SLOTS) begin
          home_nxt = home_r - HW'(SLOTS);
        end else begin
          pos_nxt   = home_r[SW-1:0];
          state_nxt = S_PRD;
        end
      end
      S_PRD: state_nxt = S_PCHK;
      S_PCHK: begin
        state_nxt = S_FIN;
        if (!rd_valid_r) begin
          if (op_r == OP_LOOKUP) begin
            res_status_nxt = STS_MISS;
            res_slot_nxt   = '0;
          end else if (32'(count_r) >= 32'(limit_r)) begin
            res_status_nxt = STS_FULL;
            res_slot_nxt   = '0;
          end else begin
            we            = 1'b1;
            w_valid       = 1'b1;
            w_home        = home_r[SW-1:0];
            w_key         = key_r;
            w_val         = '0;
            count_nxt     = count_r + 1'b1;
            res_slot_nxt  = 8'(pos_r);
            res_fresh_nxt = 1'b1;
          end
        end else if (rd_key_r == key_r) begin
          res_slot_nxt = 8'(pos_r);
          res_val_nxt  = 64'(rd_val_r);
        end else if (cnt_r == CW'(SLOTS - 1)) begin
          res_status_nxt = (op_r == OP_LOOKUP) ? STS_MISS : STS_FULL;
          res_slot_nxt   = '0;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          pos_nxt   = pos_next;
          state_nxt = S_PRD;
        end
      end
      S_TRD: state_nxt = S_TCHK;
      S_TCHK: begin
        if (!rd_valid_r) begin
          res_status_nxt = STS_EMPTY;
          state_nxt      = S_FIN;
        end else if (op_r == OP_WRITE) begin
          we          = 1'b1;
          w_valid     = 1'b1;
          w_val       = wval_r;
          res_val_nxt = 64'(wval_r);
          state_nxt   = S_FIN;
        end else begin
          hole_nxt  = pos_r;
          cnt_nxt   = CW'(1);
          pos_nxt   = pos_next;
          state_nxt = (SLOTS > 1) ? S_ERD : S_ECHK;
        end
      end
      S_ERD: state_nxt = S_ECHK;
      S_ECHK: begin
        if (!rd_valid_r ||
            (32'(cnt_r) > 32'(home_dist) && cnt_r == CW'(SLOTS - 1))) begin
          // close the run: empty the final hole
          we        = 1'b1;
          wa        = hole_r;
          w_valid   = 1'b0;
          count_nxt = (count_r != '0) ? count_r - 1'b1 : count_r;
          state_nxt = S_FIN;
        end else if (32'(cnt_r) > 32'(home_dist)) begin
          cnt_nxt   = cnt_r + 1'b1;
          pos_nxt   = pos_next;
          state_nxt = S_ERD;
        end else begin
          // pull this entry back into the hole
          we        = 1'b1;
          wa        = hole_r;
          w_valid   = 1'b1;
          hole_nxt  = pos_r;
          cnt_nxt   = CW'(1);
          pos_nxt   = pos_next;
          state_nxt = S_ERD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.result_slot    = out_slot_r;
  assign out_ch.result_value   = out_val_r;
  assign out_ch.newly_inserted = out_fresh_r;
  assign out_ch.occupied_count = out_count_r;

endmodule
`default_nettype wire

>>> rtl/core/lpht_checker.sv
// Port-level checks of the hash table result channel, bound to the top level.
// Depends on lpht_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_probe_hash_table_unit_assert.svh"
module lpht_checker
  import lpht_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  status,
  input wire [7:0]  result_slot,
  input wire [63:0] result_value,
  input wire        newly_inserted,
  input wire [8:0]  occupied_count
);

  // A stalled result beat stays valid and holds its status
  `LPHT_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(status))
  // A fresh entry is an ok result with a zero value and a nonzero count
  `LPHT_ASSERT_NOW(a_fresh_ok, out_valid && newly_inserted,
    status == STS_OK && result_value == 64'd0 && occupied_count != 9'd0)
  // Failed lookups and inserts report slot zero and value zero
  `LPHT_ASSERT_NOW(a_fail_zero, out_valid && (status == STS_MISS || status == STS_FULL),
    result_slot == 8'd0 && result_value == 64'd0)
  // A new result beat follows a busy cycle with the input closed
  `LPHT_ASSERT_NOW(a_busy_no_take, $rose(out_valid), !$past(in_ready))

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .result_slot    (out_ch.result_slot),
  .result_value   (out_ch.result_value),
  .newly_inserted (out_ch.newly_inserted),
  .occupied_count (out_ch.occupied_count)
);
`default_nettype wire

>>> sim/lpht_tb_if.sv
// Testbench constants shared by the scoreboard; the channels reuse rtl/core/lpht_if.sv.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
package lpht_tb_pkg;
  import lpht_pkg::*;
  localparam int TB_SLOTS = DEF_SLOTS;
endpackage

>>> sim/lpht_checker.sv
// Checker for the hash table: watches request, result and config beats,
// predicts each result from its own table model and compares. Needs lpht_pkg, lpht_tb_pkg.
`timescale 1ns / 1ps
module lpht_tb_checker
  import lpht_pkg::*;
  import lpht_tb_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  lpht_req_if.sink    req,
  lpht_rsp_if.sink    rsp,
  lpht_cfg_if.sink    cfg,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    status_t     status;
    logic [7:0]  slot;
    logic [63:0] value;
    logic        fresh;
    logic [8:0]  count;
  } result_t;

  logic        tbl_valid [TB_SLOTS];
  logic [63:0] tbl_key   [TB_SLOTS];
  logic [7:0]  tbl_home  [TB_SLOTS];
  logic [63:0] tbl_value [TB_SLOTS];
  logic [8:0]  tbl_count;
  logic [8:0]  tbl_limit;
  result_t     expected_results [$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Backward-shift erase starting at the hole
  function automatic void shift_erase(input logic [7:0] start);
    logic [7:0] hole;
    logic [7:0] pos;
    int k;
    hole = start;
    k = 1;
    while (k < TB_SLOTS) begin
      pos = hole + k[7:0];
      if (!tbl_valid[pos]) break;
      if (8'(pos - hole) <= 8'(pos - tbl_home[pos])) begin
        tbl_key[hole] = tbl_key[pos];
        tbl_home[hole] = tbl_home[pos];
        tbl_value[hole] = tbl_value[pos];
        hole = pos;
        k = 1;
      end else begin
        k++;
      end
    end
    tbl_valid[hole] = 1'b0;
    if (tbl_count > 0) tbl_count--;
  endfunction

  function automatic result_t predict_table_op(input op_t op, input logic [63:0] key,
      input logic [7:0] home, input logic [7:0] target, input logic [63:0] wval);
    result_t r;
    int hit;
    logic [7:0] at;
    logic [7:0] pos;
    r = '0;
    if (op == OP_LOOKUP || op == OP_INSERT) begin
      hit = -1;
      at = 0;
      for (int i = 0; i < TB_SLOTS; i++) begin
        pos = home + i[7:0];
        if (!tbl_valid[pos]) begin hit = 0; at = pos; break; end
        if (tbl_key[pos] == key) begin hit = 1; at = pos; break; end
      end
      if (hit == 1) begin
        r.slot = at;
        r.value = tbl_value[at];
      end else if (op == OP_LOOKUP) begin
        r.status = STS_MISS;
      end else if (hit == -1 || tbl_count >= tbl_limit) begin
        r.status = STS_FULL;
      end else begin
        tbl_valid[at] = 1'b1;
        tbl_key[at] = key;
        tbl_home[at] = home;
        tbl_value[at] = '0;
        tbl_count++;
        r.slot = at;
        r.fresh = 1'b1;
      end
    end else begin
      r.slot = target;
      if (!tbl_valid[target]) r.status = STS_EMPTY;
      else if (op == OP_ERASE) shift_erase(target);
      else begin
        tbl_value[target] = wval;
        r.value = wval;
      end
    end
    r.count = tbl_count;
    return r;
  endfunction

  // Predict on request beats, compare on result beats
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      tbl_count = '0;
      tbl_limit = LIMIT_RESET;
      fail_count = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      if (cfg.valid && cfg.ready) tbl_limit = cfg.load_limit;
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected beat", 64'(rsp.status), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status)
            report("status", 64'(rsp.status), 64'(want.status));
          if (rsp.result_slot !== want.slot)
            report("slot", 64'(rsp.result_slot), 64'(want.slot));
          if (rsp.result_value !== want.value) report("value", rsp.result_value, want.value);
          if (rsp.newly_inserted !== want.fresh)
            report("inserted", 64'(rsp.newly_inserted), 64'(want.fresh));
          if (rsp.occupied_count !== want.count)
            report("count", 64'(rsp.occupied_count), 64'(want.count));
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(predict_table_op(op_t'(req.opcode), req.search_key,
            req.home_slot, req.target_slot, req.write_value));
      pending = expected_results.size();
    end
  end
endmodule

>>> sim/tb.sv
// Top of the hash table testbench: clock, reset, stimulus and verdict.
// Depends on lpht_pkg, the block's interfaces, lpht_tb_checker and the block itself.
`timescale 1ns / 1ps
module tb;
  import lpht_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_off;
  int   quiet_cycles;
  logic [63:0] key_pool [16];

  lpht_req_if req_ch ();
  lpht_rsp_if rsp_ch ();
  lpht_cfg_if cfg_ch ();

  linear_probe_hash_table_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch.sink), .out_ch(rsp_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  lpht_tb_checker chk (
    .clk(clk), .rst_n(rst_n), .req(req_ch.sink), .rsp(rsp_ch.sink), .cfg(cfg_ch.sink),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Receiver: stall at random, or hold off completely when asked
  always @(negedge clk) begin
    if (!rst_n || hold_off) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no beat at all
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one beat; valid stays up afterwards so items can follow back to back
  task automatic send_item(input op_t op, input logic [63:0] key, input logic [7:0] home,
      input logic [7:0] target, input logic [63:0] wval);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.search_key <= key;
    req_ch.home_slot <= home;
    req_ch.target_slot <= target;
    req_ch.write_value <= wval;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_limit(input logic [8:0] lim);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.load_limit <= lim;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random item biased toward a small key set so hits, erases and runs happen
  task automatic random_item();
    int sel;
    logic [63:0] key;
    sel = $urandom_range(15);
    key = key_pool[sel];
    if ($urandom_range(9) == 0) key = {$urandom, $urandom};
    case ($urandom_range(9)) inside
      [0:1]: send_item(OP_LOOKUP, key, key[7:0] & 8'h1f, 8'($urandom), {$urandom, $urandom});
      [2:5]: send_item(OP_INSERT, key, key[7:0] & 8'h1f, 8'($urandom),
                       {$urandom, $urandom});
      [6:7]: send_item(OP_ERASE, key, 8'($urandom), 8'($urandom_range(40)),
                       {$urandom, $urandom});
      default: send_item(OP_WRITE, key, 8'($urandom), 8'($urandom_range(40)),
                         {$urandom, $urandom});
    endcase
  endtask

  initial begin
    rst_n = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_LOOKUP;
    req_ch.search_key = '0;
    req_ch.home_slot = '0;
    req_ch.target_slot = '0;
    req_ch.write_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.load_limit = LIMIT_RESET;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every opcode, misses, hits, wraparound, empty slots
    send_item(OP_LOOKUP, 64'h0, 8'h00, 8'h00, 64'h0);
    send_item(OP_ERASE, 64'h0, 8'h00, 8'h00, 64'h0);
    send_item(OP_WRITE, 64'h0, 8'h00, 8'hff, '1);
    send_item(OP_INSERT, '1, 8'hff, 8'h00, 64'h0);
    send_item(OP_INSERT, 64'h0, 8'hff, 8'h00, 64'h0);
    send_item(OP_INSERT, 64'h5, 8'hff, 8'h00, 64'h0);
    send_item(OP_INSERT, '1, 8'hff, 8'h00, 64'h0);
    send_item(OP_WRITE, 64'h0, 8'h00, 8'h00, '1);
    send_item(OP_LOOKUP, 64'h0, 8'hff, 8'h00, 64'h0);
    send_item(OP_WRITE, 64'h0, 8'h00, 8'hff, 64'h1234);
    send_item(OP_ERASE, 64'h0, 8'h00, 8'hff, 64'h0);
    send_item(OP_LOOKUP, 64'h5, 8'hff, 8'h00, 64'h0);
    send_item(OP_LOOKUP, 64'h0, 8'hff, 8'h00, 64'h0);
    send_item(OP_ERASE, 64'h0, 8'h00, 8'h80, 64'h0);

    // Zero limit: every new insert is full
    write_limit(9'd0);
    send_item(OP_INSERT, 64'h77, 8'h10, 8'h00, 64'h0);
    send_item(OP_INSERT, 64'h5, 8'hff, 8'h00, 64'h0);

    // Fill the whole table under the top limit, then erase through a full run
    write_limit(9'd511);
    for (int i = 0; i < 258; i++)
      send_item(OP_INSERT, 64'h1000 + i, 8'(i * 7), 8'h00, 64'h0);
    send_item(OP_LOOKUP, 64'hdead, 8'h33, 8'h00, 64'h0);
    for (int i = 0; i < 256; i++)
      send_item(OP_ERASE, 64'h0, 8'h00, 8'(i * 3), 64'h0);

    // Random phases over limits and idling mixes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_limit(9'd256); send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin write_limit(9'd12);  send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin write_limit(9'd30);  send_idle_pct = 0;  recv_stall_pct = 54; end
        3: begin write_limit(9'd1);   send_idle_pct = 16; recv_stall_pct = 16; end
        default: begin write_limit(9'd170); send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 2) begin
        // Long receiver hold-off while requests keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(negedge clk);
            hold_off = 1'b0;
          end
          repeat (10) random_item();
        join
        // Sender pause until every result is back
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      repeat (42) random_item();
    end

    drain_results();
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> linear_probe_hash_table_unit.f
+incdir+rtl/core
rtl/core/lpht_pkg.sv
rtl/core/lpht_if.sv
rtl/core/linear_probe_hash_table_unit.sv
rtl/core/lpht_checker.sv
sim/lpht_tb_if.sv
sim/lpht_checker.sv
sim/tb.sv
